// ----- hdl/superpixel_region_statistics_defines.svh -----
// Assertion macros for the region statistics block.
`ifndef SUPERPIXEL_REGION_STATISTICS_DEFINES_SVH
`define SUPERPIXEL_REGION_STATISTICS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define SRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- hdl/srs_pkg.sv -----
`default_nettype none
package srs_pkg;
  localparam int unsigned MaxLabels = 1024;
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;
  localparam int unsigned LabelW = 10;
  localparam int unsigned CoordW = 11;
  localparam int unsigned ColorW = 8;
  localparam int unsigned CountW = 23;
  localparam int unsigned SumW   = 30;
  localparam int unsigned AddrW  = $clog2(MaxLabels);
  localparam int unsigned CapVal = MaxWidth * MaxHeight;
  // packed geometry + sums word
  localparam int unsigned DataW  = 4 * CoordW + 3 * SumW;
  // divider: quotient of (2*sum+n)/(2*n), sum < 2^30 -> dividend < 2^32
  localparam int unsigned DivW   = SumW + 2;
  localparam int unsigned DenW   = CountW + 1;

  typedef enum logic [1:0] {
    OP_ACCUMULATE = 2'd0,
    OP_QUERY      = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_OUT   = 5'b01000,
    ST_CLR   = 5'b10000
  } state_e;

  typedef struct packed {
    logic [CoordW-1:0] min_x;
    logic [CoordW-1:0] max_x;
    logic [CoordW-1:0] min_y;
    logic [CoordW-1:0] max_y;
    logic [SumW-1:0]   sum_b;
    logic [SumW-1:0]   sum_g;
    logic [SumW-1:0]   sum_r;
  } region_t;
endpackage
`default_nettype wire

// ----- hdl/srs_ram.sv -----
`default_nettype none
module srs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/superpixel_region_statistics.sv -----
// Pixels (accumulate) and clears: one item per cycle while the input is not stalled,
// read-modify-write over a registered read port with forwarding from the write stage.
// Query: one memory read, then three 32-step radix-2 divisions in turn, one per
// channel mean, then the result is held in ST_OUT; an empty label takes only the first division.
// No item is taken from a query's accept until its result is taken.
// Reset: the count memory is swept to zero over all 1024 labels, input stalled during the sweep.
`default_nettype none
`include "superpixel_region_statistics_defines.svh"
module superpixel_region_statistics (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [srs_pkg::LabelW-1:0]    label_i,
  input  wire logic [srs_pkg::CoordW-1:0]    x_i,
  input  wire logic [srs_pkg::CoordW-1:0]    y_i,
  input  wire logic [srs_pkg::ColorW-1:0]    blue_i,
  input  wire logic [srs_pkg::ColorW-1:0]    green_i,
  input  wire logic [srs_pkg::ColorW-1:0]    red_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               label_empty_o,
  output logic [srs_pkg::CoordW-1:0]         box_left_o,
  output logic [srs_pkg::CoordW-1:0]         box_top_o,
  output logic [srs_pkg::CoordW-1:0]         box_width_o,
  output logic [srs_pkg::CoordW-1:0]         box_height_o,
  output logic [srs_pkg::ColorW-1:0]         mean_blue_o,
  output logic [srs_pkg::ColorW-1:0]         mean_green_o,
  output logic [srs_pkg::ColorW-1:0]         mean_red_o,
  output logic [srs_pkg::CountW-1:0]         pixel_count_o
);
  import srs_pkg::*;

  state_e state_q, state_d;

  // stage 1: item issued to memory read
  logic             s1_valid_q;
  op_e              s1_op_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_inrange_q;
  logic [CoordW-1:0] s1_x_q, s1_y_q;
  logic [ColorW-1:0] s1_b_q, s1_g_q, s1_r_q;

  // pending write (forwarding source)
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [CountW-1:0] wr_cnt;
  region_t          wr_reg;
  logic             fw_valid_q;
  logic [AddrW-1:0] fw_addr_q;
  logic [CountW-1:0] fw_cnt_q;
  region_t          fw_reg_q;

  logic [CountW-1:0] rd_cnt;
  region_t           rd_reg;
  logic [CountW-1:0] cur_cnt;
  region_t           cur_reg;

  logic [AddrW-1:0] clr_addr_q;
  logic             accept;
  logic             in_range;

  logic             cnt_we;
  logic [AddrW-1:0] cnt_waddr;
  logic [CountW-1:0] cnt_wdata;

  assign in_stall_o = !(state_q == ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = ({22'd0, label_i} < 32'(MaxLabels));

  srs_ram #(.Width(CountW), .Depth(MaxLabels)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (label_i[AddrW-1:0]),
    .rdata_o (rd_cnt)
  );

  srs_ram #(.Width(DataW), .Depth(MaxLabels)) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_reg),
    .raddr_i (label_i[AddrW-1:0]),
    .rdata_o (rd_reg)
  );

  // forward the write of the previous item to the same label
  always_comb begin
    cur_cnt = rd_cnt;
    cur_reg = rd_reg;
    if (fw_valid_q && fw_addr_q == s1_addr_q) begin
      cur_cnt = fw_cnt_q;
      cur_reg = fw_reg_q;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_addr_q;
    wr_cnt  = cur_cnt;
    wr_reg  = cur_reg;
    if (s1_valid_q && s1_inrange_q) begin
      if (s1_op_q == OP_ACCUMULATE &&
          {1'b0, s1_x_q} < 12'(MaxWidth) && {1'b0, s1_y_q} < 12'(MaxHeight) &&
          {9'd0, cur_cnt} < 32'(CapVal)) begin
        wr_en  = 1'b1;
        wr_cnt = cur_cnt + 1'b1;
        if (cur_cnt == '0) begin
          wr_reg.min_x = s1_x_q;
          wr_reg.max_x = s1_x_q;
          wr_reg.min_y = s1_y_q;
          wr_reg.max_y = s1_y_q;
          wr_reg.sum_b = SumW'(s1_b_q);
          wr_reg.sum_g = SumW'(s1_g_q);
          wr_reg.sum_r = SumW'(s1_r_q);
        end else begin
          if (s1_x_q < cur_reg.min_x) wr_reg.min_x = s1_x_q;
          if (s1_x_q > cur_reg.max_x) wr_reg.max_x = s1_x_q;
          if (s1_y_q < cur_reg.min_y) wr_reg.min_y = s1_y_q;
          if (s1_y_q > cur_reg.max_y) wr_reg.max_y = s1_y_q;
          wr_reg.sum_b = cur_reg.sum_b + SumW'(s1_b_q);
          wr_reg.sum_g = cur_reg.sum_g + SumW'(s1_g_q);
          wr_reg.sum_r = cur_reg.sum_r + SumW'(s1_r_q);
        end
      end else if (s1_op_q == OP_CLEAR) begin
        wr_en  = 1'b1;
        wr_cnt = '0;
      end
    end
  end

  always_comb begin
    cnt_we    = wr_en;
    cnt_waddr = wr_addr;
    cnt_wdata = wr_cnt;
    if (state_q == ST_CLR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr_q;
      cnt_wdata = '0;
    end
  end

  // query capture and divider
  logic [CountW-1:0] q_cnt_q;
  region_t           q_reg_q;
  logic              q_empty_q;
  logic [1:0]        ch_q;
  logic [5:0]        bit_q;
  logic [DivW-1:0]   num_q;
  logic [DenW:0]     rem_q;
  logic [DivW-1:0]   quo_q;
  logic [ColorW-1:0] mb_q, mg_q, mr_q;
  logic [DenW-1:0]   den;
  logic [DenW:0]     rem_sh;
  logic [DivW-1:0]   quo_nx;
  logic [DenW:0]     rem_nx;
  logic              div_last;

  assign den    = {q_cnt_q, 1'b0};
  assign rem_sh = {rem_q[DenW-1:0], num_q[DivW-1]};
  always_comb begin
    rem_nx = rem_sh;
    quo_nx = {quo_q[DivW-2:0], 1'b0};
    if (rem_sh >= {1'b0, den}) begin
      rem_nx    = rem_sh - {1'b0, den};
      quo_nx[0] = 1'b1;
    end
  end
  assign div_last = (bit_q == 6'(DivW - 1));

  function automatic logic [DivW-1:0] div_num(input logic [SumW-1:0] s,
                                              input logic [CountW-1:0] n);
    div_num = {s, 1'b0} + DivW'(n);
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_addr_q == AddrW'(MaxLabels - 1)) state_d = ST_IDLE;
      ST_IDLE: if (accept && operation_i == OP_QUERY) state_d = ST_READ;
      ST_READ: state_d = ST_DIV;
      ST_DIV:  if (div_last && (ch_q == 2'd2 || q_empty_q)) state_d = ST_OUT;
      ST_OUT:  if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      clr_addr_q <= '0;
      s1_valid_q <= 1'b0;
      fw_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (state_q == ST_CLR) clr_addr_q <= clr_addr_q + 1'b1;
      s1_valid_q <= accept;
      fw_valid_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q      <= op_e'(operation_i);
      s1_addr_q    <= label_i[AddrW-1:0];
      s1_inrange_q <= in_range;
      s1_x_q <= x_i;
      s1_y_q <= y_i;
      s1_b_q <= blue_i;
      s1_g_q <= green_i;
      s1_r_q <= red_i;
    end
    fw_addr_q <= wr_addr;
    fw_cnt_q  <= wr_cnt;
    fw_reg_q  <= wr_reg;
    if (state_q == ST_READ) begin
      q_cnt_q   <= cur_cnt;
      q_reg_q   <= cur_reg;
      q_empty_q <= !s1_inrange_q || cur_cnt == '0;
      ch_q      <= 2'd0;
      bit_q     <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      num_q     <= div_num(cur_reg.sum_b, cur_cnt);
    end else if (state_q == ST_DIV) begin
      if (div_last) begin
        case (ch_q)
          2'd0:    mb_q <= quo_nx[ColorW-1:0];
          2'd1:    mg_q <= quo_nx[ColorW-1:0];
          default: mr_q <= quo_nx[ColorW-1:0];
        endcase
        ch_q  <= ch_q + 1'b1;
        bit_q <= '0;
        rem_q <= '0;
        quo_q <= '0;
        num_q <= (ch_q == 2'd0) ? div_num(q_reg_q.sum_g, q_cnt_q)
                                : div_num(q_reg_q.sum_r, q_cnt_q);
      end else begin
        bit_q <= bit_q + 1'b1;
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        num_q <= {num_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign out_valid_o   = (state_q == ST_OUT);
  assign label_empty_o = q_empty_q;
  assign box_left_o    = q_empty_q ? '0 : q_reg_q.min_x;
  assign box_top_o     = q_empty_q ? '0 : q_reg_q.min_y;
  assign box_width_o   = q_empty_q ? '0 : q_reg_q.max_x - q_reg_q.min_x;
  assign box_height_o  = q_empty_q ? '0 : q_reg_q.max_y - q_reg_q.min_y;
  assign mean_blue_o   = q_empty_q ? '0 : mb_q;
  assign mean_green_o  = q_empty_q ? '0 : mg_q;
  assign mean_red_o    = q_empty_q ? '0 : mr_q;
  assign pixel_count_o = q_empty_q ? '0 : q_cnt_q;

  `SRS_ASSERT_IMPL(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q), "state not one-hot")
  `SRS_ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, state_q != ST_IDLE, !accept, "item taken while busy")
  `SRS_ASSERT_NEXT(a_query_read, clk_i, rst_ni, accept && operation_i == OP_QUERY, state_q == ST_READ, "query did not read")
  `SRS_ASSERT_IMPL(a_write_idle, clk_i, rst_ni, state_q == ST_CLR, !wr_en, "write during clear sweep")
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import srs_pkg::*;

  typedef struct {
    logic              empty;
    logic [CoordW-1:0] left, top, width, height;
    logic [ColorW-1:0] mb, mg, mr;
    logic [CountW-1:0] count;
  } stats_t;

  typedef struct {
    op_e               op;
    logic [LabelW-1:0] label;
    logic [CoordW-1:0] x, y;
    logic [ColorW-1:0] b, g, r;
    bit                typed;
    stats_t            res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [1:0] operation_i = OP_NONE;
  logic [LabelW-1:0] label_i = '0;
  logic [CoordW-1:0] x_i = '0, y_i = '0;
  logic [ColorW-1:0] blue_i = '0, green_i = '0, red_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, label_empty_o;
  logic [CoordW-1:0] box_left_o, box_top_o, box_width_o, box_height_o;
  logic [ColorW-1:0] mean_blue_o, mean_green_o, mean_red_o;
  logic [CountW-1:0] pixel_count_o;

  superpixel_region_statistics dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the label stores
  logic [CountW-1:0] cnt_mem [MaxLabels];
  logic [CoordW-1:0] minx_mem [MaxLabels], maxx_mem [MaxLabels];
  logic [CoordW-1:0] miny_mem [MaxLabels], maxy_mem [MaxLabels];
  longint unsigned   sumb_mem [MaxLabels], sumg_mem [MaxLabels], sumr_mem [MaxLabels];

  stats_t pending_stats [$];
  row_t   directed [$];
  int     errors = 0;
  int     cycles = 0;
  bit     sender_quiet = 1'b0;

  function automatic logic [ColorW-1:0] round_mean(longint unsigned s, longint unsigned n);
    return ColorW'((2 * s + n) / (2 * n));
  endfunction

  function automatic stats_t region_lookup(logic [LabelW-1:0] l);
    stats_t s;
    s = '{default: '0};
    if (cnt_mem[l] == 0) begin
      s.empty = 1'b1;
    end else begin
      s.left   = minx_mem[l];
      s.top    = miny_mem[l];
      s.width  = maxx_mem[l] - minx_mem[l];
      s.height = maxy_mem[l] - miny_mem[l];
      s.mb     = round_mean(sumb_mem[l], cnt_mem[l]);
      s.mg     = round_mean(sumg_mem[l], cnt_mem[l]);
      s.mr     = round_mean(sumr_mem[l], cnt_mem[l]);
      s.count  = cnt_mem[l];
    end
    return s;
  endfunction

  // update the shadow stores; queue a result for a query
  task automatic region_update(row_t t);
    case (t.op)
      OP_ACCUMULATE: begin
        if (cnt_mem[t.label] < CapVal) begin
          if (cnt_mem[t.label] == 0) begin
            minx_mem[t.label] = t.x; maxx_mem[t.label] = t.x;
            miny_mem[t.label] = t.y; maxy_mem[t.label] = t.y;
            sumb_mem[t.label] = 0; sumg_mem[t.label] = 0; sumr_mem[t.label] = 0;
          end else begin
            if (t.x < minx_mem[t.label]) minx_mem[t.label] = t.x;
            if (t.x > maxx_mem[t.label]) maxx_mem[t.label] = t.x;
            if (t.y < miny_mem[t.label]) miny_mem[t.label] = t.y;
            if (t.y > maxy_mem[t.label]) maxy_mem[t.label] = t.y;
          end
          cnt_mem[t.label]++;
          sumb_mem[t.label] += t.b;
          sumg_mem[t.label] += t.g;
          sumr_mem[t.label] += t.r;
        end
      end
      OP_CLEAR: cnt_mem[t.label] = '0;
      OP_QUERY: pending_stats.push_back(t.typed ? t.res : region_lookup(t.label));
      default: ;
    endcase
  endtask

  task automatic send_item(row_t t, bit may_idle);
    if (may_idle && !sender_quiet && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= t.op;
    label_i     <= t.label;
    x_i <= t.x; y_i <= t.y;
    blue_i <= t.b; green_i <= t.g; red_i <= t.r;
    do @(posedge clk_i); while (in_stall_o);
    region_update(t);
    @(negedge clk_i);
  endtask

  function automatic row_t mk(op_e op, int l, int x, int y, int b, int g, int r);
    row_t t;
    t.op = op; t.label = l; t.x = x; t.y = y; t.b = b; t.g = g; t.r = r;
    t.typed = 1'b0;
    t.res = '{default: '0};
    return t;
  endfunction

  function automatic row_t mk_typed(int l, stats_t s);
    row_t t;
    t = mk(OP_QUERY, l, 0, 0, 0, 0, 0);
    t.typed = 1'b1;
    t.res = s;
    return t;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual label_empty=%0b count=%0d",
                 $time, label_empty_o, pixel_count_o);
      end else begin
        e = pending_stats.pop_front();
        check_field("label_empty", e.empty, label_empty_o);
        check_field("box_left", e.left, box_left_o);
        check_field("box_top", e.top, box_top_o);
        check_field("box_width", e.width, box_width_o);
        check_field("box_height", e.height, box_height_o);
        check_field("mean_blue", e.mb, mean_blue_o);
        check_field("mean_green", e.mg, mean_green_o);
        check_field("mean_red", e.mr, mean_red_o);
        check_field("pixel_count", e.count, pixel_count_o);
      end
    end
  end

  // receiver: random stalls, one long hold-off, one quiet window
  always @(negedge clk_i) begin
    if (cycles >= 3000 && cycles < 3400)
      out_stall_i <= 1'b1;
    else if (cycles >= 6000 && cycles < 8000)
      out_stall_i <= 1'b0;
    else
      out_stall_i <= ($urandom_range(99) < 9);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [LabelW-1:0] hot [16];
    row_t t;
    int   pick;
    for (int i = 0; i < MaxLabels; i++) cnt_mem[i] = '0;
    for (int i = 0; i < 16; i++) hot[i] = $urandom_range(0, MaxLabels - 1);

    directed.push_back(mk_typed(0, '{empty: 1'b1, default: '0}));
    directed.push_back(mk(OP_ACCUMULATE, 1023, 0, 0, 0, 0, 0));
    directed.push_back(mk_typed(1023, '{empty: 1'b0, left: 0, top: 0, width: 0, height: 0,
                                        mb: 0, mg: 0, mr: 0, count: 1}));
    directed.push_back(mk(OP_ACCUMULATE, 1023, 2047, 2047, 255, 255, 255));
    directed.push_back(mk_typed(1023, '{empty: 1'b0, left: 0, top: 0, width: 2047,
                                        height: 2047, mb: 128, mg: 128, mr: 128, count: 2}));
    directed.push_back(mk(OP_NONE, 1023, 5, 5, 5, 5, 5));
    directed.push_back(mk_typed(1023, '{empty: 1'b0, left: 0, top: 0, width: 2047,
                                        height: 2047, mb: 128, mg: 128, mr: 128, count: 2}));
    directed.push_back(mk(OP_CLEAR, 1023, 0, 0, 0, 0, 0));
    directed.push_back(mk_typed(1023, '{empty: 1'b1, default: '0}));
    directed.push_back(mk(OP_ACCUMULATE, 5, 100, 200, 1, 2, 3));
    directed.push_back(mk(OP_ACCUMULATE, 5, 50, 300, 2, 250, 7));
    directed.push_back(mk(OP_ACCUMULATE, 5, 70, 100, 200, 9, 0));
    directed.push_back(mk(OP_QUERY, 5, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_CLEAR, 5, 0, 0, 0, 0, 0));
    // first pixel after a clear must reseed the box and sums
    directed.push_back(mk(OP_ACCUMULATE, 5, 1500, 20, 9, 9, 9));
    directed.push_back(mk(OP_QUERY, 5, 0, 0, 0, 0, 0));
    // half-way mean rounds up
    directed.push_back(mk(OP_ACCUMULATE, 7, 3, 4, 0, 1, 254));
    directed.push_back(mk(OP_ACCUMULATE, 7, 3, 4, 1, 2, 255));
    directed.push_back(mk(OP_QUERY, 7, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_typed(0, '{empty: 1'b1, default: '0}));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_item(directed[i], 1'b1);

    for (int n = 0; n < 1900; n++) begin
      sender_quiet = (n >= 500 && n < 800);
      if (n == 1200) begin
        in_valid_i <= 1'b0;
        while (pending_stats.size() != 0) @(negedge clk_i);
      end
      pick = $urandom_range(99);
      t = mk(OP_ACCUMULATE, ($urandom_range(9) == 0) ? $urandom_range(0, MaxLabels - 1)
                                                   : hot[$urandom_range(0, 15)],
             $urandom_range(0, 2047), $urandom_range(0, 2047),
             $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      if (pick < 10) t.op = OP_QUERY;
      else if (pick < 13) t.op = OP_CLEAR;
      else if (pick < 15) t.op = OP_NONE;
      send_item(t, 1'b1);
    end
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
